FILE: hdl/lssi_pkg.sv
// Shared types and constants for the sorted-insert LIFO stack.
// Used by the controller, the datapath, the top level and the checker.
`default_nettype none

package lssi_pkg;

    localparam int LSSI_DEPTH = 128;
    localparam logic [7:0] LSSI_CAP_RESET = 8'd128;

    typedef enum logic [1:0] {
        CMD_PUSH   = 2'd0,
        CMD_POP    = 2'd1,
        CMD_PEEK   = 2'd2,
        CMD_INSERT = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } t_status;

    // What goes into the result register
    typedef enum logic [1:0] {
        RES_OK,
        RES_OVF,
        RES_UNF,
        RES_TOP
    } t_res_sel;

    typedef enum logic [1:0] {
        S_IDLE,
        S_TOP,
        S_INS_RD,
        S_INS_CMP
    } t_state;

    typedef struct packed {
        t_cmd               command;
        logic signed [31:0] value;
    } t_in;

    typedef struct packed {
        logic signed [31:0] value_res;
        t_status            status;
        logic [7:0]         count;
    } t_res;

    // Controller to datapath
    typedef struct packed {
        logic     latch;
        logic     push_wr;
        logic     rd_top;
        logic     idx_load;
        logic     rd_idx;
        logic     shift_wr;
        logic     ins_wr;
        logic     pop_dec;
        logic     res_load;
        t_res_sel res_sel;
    } t_dp_ctl;

    // Datapath to controller
    typedef struct packed {
        logic full;
        logic empty;
        logic idx_zero;
        logic greater;
        logic pop;
    } t_dp_stat;

endpackage

`default_nettype wire

FILE: hdl/lssi_ctrl.sv
// Controller state machine of the sorted-insert stack.
// Depends on lssi_pkg; drives lssi_dp through t_dp_ctl.
`default_nettype none

module lssi_ctrl
    import lssi_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_start,
    input  wire t_cmd     i_command,
    input  wire t_dp_stat i_stat,
    output t_dp_ctl       o_ctl,
    output logic          o_busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    unique case (i_command) inside
                        CMD_PUSH: n_state = S_IDLE;
                        CMD_INSERT: begin
                            n_state = i_stat.full ? S_IDLE : S_INS_RD;
                        end
                        CMD_POP, CMD_PEEK: begin
                            n_state = i_stat.empty ? S_IDLE : S_TOP;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_TOP:     n_state = S_IDLE;
            S_INS_RD:  n_state = i_stat.idx_zero ? S_IDLE : S_INS_CMP;
            S_INS_CMP: n_state = i_stat.greater ? S_INS_RD : S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ctl = '0;
        o_ctl.res_sel = RES_OK;
        o_busy = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_ctl.latch = 1'b1;
                    unique case (i_command) inside
                        CMD_PUSH, CMD_INSERT: begin
                            if (i_stat.full) begin
                                o_ctl.res_load = 1'b1;
                                o_ctl.res_sel  = RES_OVF;
                            end else if (i_command == CMD_PUSH) begin
                                o_ctl.push_wr  = 1'b1;
                                o_ctl.res_load = 1'b1;
                            end else begin
                                o_ctl.idx_load = 1'b1;
                            end
                        end
                        CMD_POP, CMD_PEEK: begin
                            if (i_stat.empty) begin
                                o_ctl.res_load = 1'b1;
                                o_ctl.res_sel  = RES_UNF;
                            end else begin
                                o_ctl.rd_top = 1'b1;
                            end
                        end
                        default: o_ctl.latch = 1'b1;
                    endcase
                end
            end
            S_TOP: begin
                o_ctl.res_load = 1'b1;
                o_ctl.res_sel  = RES_TOP;
                o_ctl.pop_dec  = i_stat.pop;
            end
            S_INS_RD: begin
                if (i_stat.idx_zero) begin
                    o_ctl.ins_wr   = 1'b1;
                    o_ctl.res_load = 1'b1;
                end else begin
                    o_ctl.rd_idx = 1'b1;
                end
            end
            S_INS_CMP: begin
                // Move the larger entry up one place, or drop the word in here
                if (i_stat.greater) begin
                    o_ctl.shift_wr = 1'b1;
                end else begin
                    o_ctl.ins_wr   = 1'b1;
                    o_ctl.res_load = 1'b1;
                end
            end
            default: o_busy = 1'b1;
        endcase
    end

endmodule

`default_nettype wire

FILE: hdl/lssi_dp.sv
// Datapath of the sorted-insert stack: entry memory, occupancy, insert index,
// capacity register and result register. Depends on lssi_pkg.
`default_nettype none

module lssi_dp
    import lssi_pkg::*;
#(
    parameter int DEPTH = LSSI_DEPTH
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_in        i_item,
    input  wire t_dp_ctl    i_ctl,
    input  wire logic       i_cfg_we,
    input  wire logic [7:0] i_cfg_wdata,
    output t_dp_stat        o_stat,
    output t_res            o_res,
    output logic            o_res_valid
);

    localparam int OW = $clog2(DEPTH + 1);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = (OW > 8) ? OW : 8;

    logic signed [31:0] mem [DEPTH];

    logic [7:0]         r_cap;
    logic [OW-1:0]      r_occ;
    logic [OW-1:0]      n_occ;
    logic [OW-1:0]      r_idx;
    logic [OW-1:0]      n_idx;
    logic signed [31:0] r_word;
    t_cmd               r_cmd;
    logic signed [31:0] r_rd_data;
    t_res               r_res;
    t_res               n_res;
    logic               r_res_valid;

    logic [CW-1:0]      w_cap_ext;
    logic [CW-1:0]      w_eff_cap;
    logic [OW-1:0]      w_occ_m1;
    logic [OW-1:0]      w_idx_m1;
    logic               w_we;
    logic [AW-1:0]      w_waddr;
    logic signed [31:0] w_wdata;
    logic               w_re;
    logic [AW-1:0]      w_raddr;

    assign w_cap_ext = CW'(r_cap);
    assign w_eff_cap = (w_cap_ext > CW'(DEPTH)) ? CW'(DEPTH) : w_cap_ext;
    assign w_occ_m1  = r_occ - OW'(1);
    assign w_idx_m1  = r_idx - OW'(1);

    assign o_stat.full     = (CW'(r_occ) >= w_eff_cap);
    assign o_stat.empty    = (r_occ == '0);
    assign o_stat.idx_zero = (r_idx == '0);
    assign o_stat.greater  = (r_rd_data > r_word);
    assign o_stat.pop      = (r_cmd == CMD_POP);

    always_comb begin
        n_occ = r_occ;
        if (i_ctl.push_wr || i_ctl.ins_wr) begin
            n_occ = r_occ + OW'(1);
        end else if (i_ctl.pop_dec) begin
            n_occ = w_occ_m1;
        end
    end

    always_comb begin
        n_idx = r_idx;
        if (i_ctl.idx_load) begin
            n_idx = r_occ;
        end else if (i_ctl.shift_wr) begin
            n_idx = w_idx_m1;
        end
    end

    // One write and one read port on the entry memory
    assign w_we    = i_ctl.push_wr || i_ctl.shift_wr || i_ctl.ins_wr;
    assign w_waddr = i_ctl.push_wr ? r_occ[AW-1:0] : r_idx[AW-1:0];
    assign w_wdata = i_ctl.push_wr  ? i_item.value :
                     i_ctl.shift_wr ? r_rd_data : r_word;
    assign w_re    = i_ctl.rd_top || i_ctl.rd_idx;
    assign w_raddr = i_ctl.rd_top ? w_occ_m1[AW-1:0] : w_idx_m1[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rd_data <= mem[w_raddr];
        end
    end

    always_comb begin
        n_res.value_res = '0;
        n_res.status    = ST_OK;
        n_res.count     = 8'(n_occ);
        case (i_ctl.res_sel)
            RES_OVF: n_res.status    = ST_OVERFLOW;
            RES_UNF: n_res.status    = ST_UNDERFLOW;
            RES_TOP: n_res.value_res = r_rd_data;
            default: n_res.status    = ST_OK;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= LSSI_CAP_RESET;
            r_occ       <= '0;
            r_res_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            r_occ       <= n_occ;
            r_res_valid <= i_ctl.res_load;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (i_ctl.latch) begin
            r_word <= i_item.value;
            r_cmd  <= i_item.command;
        end
        if (i_ctl.res_load) begin
            r_res <= n_res;
        end
    end

    assign o_res       = r_res;
    assign o_res_valid = r_res_valid;

endmodule

`default_nettype wire

FILE: hdl/lifo_stack_sorted_insert_core.sv
// Top level of the sorted-insert LIFO stack: controller plus datapath.
// Depends on lssi_pkg, lssi_ctrl and lssi_dp.
//
//  channel   handshake                       payload
//  command   start, busy (start & !busy)     i_cmd       (t_in)
//  result    o_res_valid, one-cycle strobe   o_res       (t_res)
//  config    i_cfg_we                        i_cfg_wdata (capacity limit)
//
// Push and every overflow or underflow: the result strobes the cycle after the
// transfer and busy stays low. Pop and peek: one memory read at the transfer,
// then the result register loads the read word in S_TOP. Sorted insert: each
// entry examined is read, then compared and, if larger, shifted up one place;
// the word goes where the comparison stops, or to the bottom. The single port
// pair of the entry memory means one entry is examined at a time.
// Synchronous active-low reset empties the stack and sets the limit to 128.
// Results cannot be held off by the receiver.
`default_nettype none

module lifo_stack_sorted_insert_core
    import lssi_pkg::*;
#(
    parameter int DEPTH = LSSI_DEPTH
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire t_in        i_cmd,
    output logic            o_res_valid,
    output t_res            o_res,
    input  wire logic       i_cfg_we,
    input  wire logic [7:0] i_cfg_wdata
);

    t_dp_ctl  w_ctl;
    t_dp_stat w_stat;

    lssi_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_command (i_cmd.command),
        .i_stat    (w_stat),
        .o_ctl     (w_ctl),
        .o_busy    (busy)
    );

    lssi_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_cmd),
        .i_ctl       (w_ctl),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_stat      (w_stat),
        .o_res       (o_res),
        .o_res_valid (o_res_valid)
    );

endmodule

`default_nettype wire

FILE: hdl/lssi_checker.sv
// Port-level checks of the sorted-insert stack, bound to the top level.
// Depends on lssi_pkg and lifo_stack_sorted_insert_core.
`default_nettype none

module lssi_checker
    import lssi_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic o_res_valid,
    input wire t_res o_res
);

    // Every result comes from a transfer or from work in progress
    a_res_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> $past(start || busy))
        else $error("result strobe without a transfer or work in progress");

    // A transfer either finishes at once or keeps the block busy
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (o_res_valid || busy))
        else $error("transfer produced neither a result nor busy");

    // Ending a multi-cycle command delivers its result
    a_busy_end_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_res_valid)
        else $error("busy dropped without a result");

    // Errors and underflow carry no word, and underflow means an empty stack
    a_error_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && (o_res.status == ST_UNDERFLOW || o_res.status == ST_OVERFLOW))
        |-> (o_res.value_res == '0 &&
             (o_res.status == ST_OVERFLOW || o_res.count == '0)))
        else $error("error result with nonzero word or underflow with entries");

endmodule

bind lifo_stack_sorted_insert_core lssi_checker u_lssi_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_res_valid (o_res_valid),
    .o_res       (o_res)
);

`default_nettype wire
